[hw/rtl/bcpe_pkg.sv]
package bcpe_pkg;

	localparam int T_FRAC_BITS = 16;
	localparam int COORD_BITS = 10;
	localparam int DEF_MAX_POINTS = 8;
	localparam int LIMB_W = 16;
	localparam int CNT_W = 4;
	localparam int PCOUNT_W = 4;
	localparam logic [PCOUNT_W-1:0] PCOUNT_RST = 4'd6;
	localparam logic [T_FRAC_BITS:0] T_ONE = (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;

	typedef struct packed {
		logic                   mode;
		logic [2:0]             point_index;
		logic [COORD_BITS-1:0]  point_x;
		logic [COORD_BITS-1:0]  point_y;
		logic [T_FRAC_BITS:0]   t_value;
	} in_item_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] curve_x;
		logic [COORD_BITS-1:0] curve_y;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_LOAD,
		ST_MUL,
		ST_ACC,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic             wr_pt;
		logic             capture;
		logic             acc_init;
		logic             load_term;
		logic             mul;
		logic             sel_t;
		logic             acc;
		logic             first;
		logic             emit;
		logic [CNT_W-1:0] n;
		logic [CNT_W-1:0] i;
		logic [CNT_W-1:0] k;
	} cmd_t;

	function automatic int term_limbs(int maxp);
		return ((maxp - 1) * T_FRAC_BITS + 1 + LIMB_W - 1) / LIMB_W;
	endfunction

	function automatic int acc_limbs(int maxp);
		return ((maxp - 1) * T_FRAC_BITS + COORD_BITS + 2 + LIMB_W - 1) / LIMB_W;
	endfunction

	function automatic int binom_f(int n, int k);
		int row [16];
		for (int a = 0; a < 16; a++) row[a] = 0;
		row[0] = 1;
		for (int r = 1; r < 16; r++) begin
			if (r <= n) begin
				for (int j = 15; j >= 1; j--) begin
					if (j <= r) row[j] = row[j] + row[j-1];
				end
			end
		end
		return row[k];
	endfunction

	function automatic logic [COORD_BITS-1:0] def_x(int i);
		case (i)
			0: def_x = COORD_BITS'(50);
			1: def_x = COORD_BITS'(270);
			2: def_x = COORD_BITS'(350);
			3: def_x = COORD_BITS'(490);
			4: def_x = COORD_BITS'(550);
			5: def_x = COORD_BITS'(650);
			default: def_x = '0;
		endcase
	endfunction

	function automatic logic [COORD_BITS-1:0] def_y(int i);
		case (i)
			0: def_y = COORD_BITS'(200);
			1: def_y = COORD_BITS'(400);
			2: def_y = COORD_BITS'(100);
			3: def_y = COORD_BITS'(450);
			4: def_y = COORD_BITS'(150);
			5: def_y = COORD_BITS'(300);
			default: def_y = '0;
		endcase
	endfunction

endpackage

[hw/rtl/bcpe_ctrl.sv]
module bcpe_ctrl #(
	parameter int MAX_POINTS = bcpe_pkg::DEF_MAX_POINTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          mode,
	input  logic                          cfg_we,
	input  logic [bcpe_pkg::PCOUNT_W-1:0] cfg_wdata,
	output logic                          busy,
	output logic                          done,
	output bcpe_pkg::cmd_t                cmd
);

	localparam int NL = bcpe_pkg::term_limbs(MAX_POINTS);
	localparam int NAL = bcpe_pkg::acc_limbs(MAX_POINTS);
	localparam int CW = bcpe_pkg::CNT_W;

	bcpe_pkg::state_t state_q, state_d;
	logic [bcpe_pkg::PCOUNT_W-1:0] pc_q;
	logic [CW-1:0] n_q, i_q, j_q, k_q, n_eff;
	logic done_q;
	logic mul_last, acc_last;

	assign mul_last = (k_q == CW'(NL - 1));
	assign acc_last = (k_q == CW'(NAL - 1));

	always_comb begin
		if (pc_q == '0) begin
			n_eff = '0;
		end else if ({1'b0, pc_q} > 5'(MAX_POINTS)) begin
			n_eff = CW'(MAX_POINTS - 1);
		end else begin
			n_eff = CW'(pc_q - 1'b1);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bcpe_pkg::ST_IDLE: begin
				if (start && mode) state_d = bcpe_pkg::ST_INIT;
			end
			bcpe_pkg::ST_INIT: state_d = bcpe_pkg::ST_LOAD;
			bcpe_pkg::ST_LOAD: begin
				state_d = (n_q == '0) ? bcpe_pkg::ST_ACC : bcpe_pkg::ST_MUL;
			end
			bcpe_pkg::ST_MUL: begin
				if (mul_last && (j_q == n_q - 1'b1)) state_d = bcpe_pkg::ST_ACC;
			end
			bcpe_pkg::ST_ACC: begin
				if (acc_last) begin
					state_d = (i_q == n_q) ? bcpe_pkg::ST_EMIT : bcpe_pkg::ST_LOAD;
				end
			end
			bcpe_pkg::ST_EMIT: state_d = bcpe_pkg::ST_IDLE;
			default: state_d = bcpe_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.n = n_q;
		cmd.i = i_q;
		cmd.k = k_q;
		cmd.first = (k_q == '0);
		cmd.sel_t = (j_q < i_q);
		case (state_q)
			bcpe_pkg::ST_IDLE: begin
				cmd.wr_pt = start && !mode;
				cmd.capture = start && mode;
			end
			bcpe_pkg::ST_INIT: cmd.acc_init = 1'b1;
			bcpe_pkg::ST_LOAD: cmd.load_term = 1'b1;
			bcpe_pkg::ST_MUL: cmd.mul = 1'b1;
			bcpe_pkg::ST_ACC: cmd.acc = 1'b1;
			bcpe_pkg::ST_EMIT: cmd.emit = 1'b1;
			default: cmd.emit = 1'b0;
		endcase
	end

	assign busy = (state_q != bcpe_pkg::ST_IDLE);
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcpe_pkg::ST_IDLE;
			pc_q <= bcpe_pkg::PCOUNT_RST;
			n_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == bcpe_pkg::ST_EMIT);
			if (cfg_we) pc_q <= cfg_wdata;
			case (state_q)
				bcpe_pkg::ST_IDLE: begin
					if (start && mode) n_q <= n_eff;
				end
				bcpe_pkg::ST_INIT: i_q <= '0;
				bcpe_pkg::ST_LOAD: begin
					j_q <= '0;
					k_q <= '0;
				end
				bcpe_pkg::ST_MUL: begin
					if (mul_last) begin
						k_q <= '0;
						j_q <= j_q + 1'b1;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				bcpe_pkg::ST_ACC: begin
					if (acc_last) begin
						k_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				default: k_q <= k_q;
			endcase
		end
	end

endmodule

[hw/rtl/bcpe_dp.sv]
module bcpe_dp #(
	parameter int MAX_POINTS = bcpe_pkg::DEF_MAX_POINTS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bcpe_pkg::cmd_t      cmd,
	input  bcpe_pkg::in_item_t  item,
	output bcpe_pkg::out_item_t result
);

	localparam int TF = bcpe_pkg::T_FRAC_BITS;
	localparam int CB = bcpe_pkg::COORD_BITS;
	localparam int LW = bcpe_pkg::LIMB_W;
	localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int NMAX = MAX_POINTS - 1;
	localparam int NL = bcpe_pkg::term_limbs(MAX_POINTS);
	localparam int NAL = bcpe_pkg::acc_limbs(MAX_POINTS);
	localparam int TKW = $clog2(NL);
	localparam int AKW = $clog2(NAL);
	localparam int TBITS = NL * LW;
	localparam int ABITS = NAL * LW;

	logic [CB-1:0] px_q [MAX_POINTS];
	logic [CB-1:0] py_q [MAX_POINTS];
	logic [TF:0] t_q, u_q;
	logic [TBITS-1:0] term_q;
	logic [ABITS-1:0] accx_q, accy_q;
	logic [TF:0] mcarry_q;
	logic [CB:0] xcarry_q, ycarry_q;
	bcpe_pkg::out_item_t res_q;

	logic [LW-1:0] btab [MAX_POINTS][MAX_POINTS];
	logic [PW-1:0] n_p, i_p, wr_p;
	logic [TKW-1:0] kt;
	logic [AKW-1:0] ka;
	logic [LW-1:0] tl_m, tl_a;
	logic [TF:0] m_sel;
	logic [LW+TF:0] prod;
	logic [LW+CB:0] sx, sy;
	logic [ABITS-1:0] rnd;
	logic [CB-1:0] ex_x, ex_y;
	logic wr_ok;

	always_comb begin
		for (int a = 0; a < MAX_POINTS; a++) begin
			for (int b = 0; b < MAX_POINTS; b++) begin
				btab[a][b] = LW'(bcpe_pkg::binom_f(a, b));
			end
		end
	end

	assign n_p = cmd.n[PW-1:0];
	assign i_p = cmd.i[PW-1:0];
	assign kt = cmd.k[TKW-1:0];
	assign ka = cmd.k[AKW-1:0];
	assign wr_p = PW'({2'b00, item.point_index});
	assign wr_ok = ({2'b00, item.point_index} < 5'(MAX_POINTS));

	assign tl_m = term_q[kt*LW +: LW];
	assign tl_a = ({1'b0, cmd.k} < (bcpe_pkg::CNT_W+1)'(NL)) ? term_q[kt*LW +: LW] : '0;
	assign m_sel = cmd.sel_t ? t_q : u_q;
	assign prod = (LW+TF+1)'(tl_m * m_sel) + (LW+TF+1)'(cmd.first ? '0 : mcarry_q);
	assign sx = (LW+CB+1)'(accx_q[ka*LW +: LW]) + (LW+CB+1)'(tl_a * px_q[i_p])
		+ (LW+CB+1)'(cmd.first ? '0 : xcarry_q);
	assign sy = (LW+CB+1)'(accy_q[ka*LW +: LW]) + (LW+CB+1)'(tl_a * py_q[i_p])
		+ (LW+CB+1)'(cmd.first ? '0 : ycarry_q);

	always_comb begin
		rnd = '0;
		for (int v = 1; v <= NMAX; v++) begin
			if (n_p == PW'(v)) rnd[v*TF-1] = 1'b1;
		end
	end

	always_comb begin
		ex_x = accx_q[CB-1:0];
		ex_y = accy_q[CB-1:0];
		for (int v = 1; v <= NMAX; v++) begin
			if (n_p == PW'(v)) begin
				ex_x = accx_q[v*TF +: CB];
				ex_y = accy_q[v*TF +: CB];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < MAX_POINTS; p++) begin
				px_q[p] <= bcpe_pkg::def_x(p);
				py_q[p] <= bcpe_pkg::def_y(p);
			end
		end else if (cmd.wr_pt && wr_ok) begin
			px_q[wr_p] <= item.point_x;
			py_q[wr_p] <= item.point_y;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			t_q <= (item.t_value > bcpe_pkg::T_ONE) ? bcpe_pkg::T_ONE : item.t_value;
			u_q <= bcpe_pkg::T_ONE - ((item.t_value > bcpe_pkg::T_ONE) ?
				bcpe_pkg::T_ONE : item.t_value);
		end
		if (cmd.acc_init) begin
			accx_q <= rnd;
			accy_q <= rnd;
		end
		if (cmd.load_term) term_q <= TBITS'(btab[n_p][i_p]);
		if (cmd.mul) begin
			term_q[kt*LW +: LW] <= prod[LW-1:0];
			mcarry_q <= prod[LW +: TF+1];
		end
		if (cmd.acc) begin
			accx_q[ka*LW +: LW] <= sx[LW-1:0];
			accy_q[ka*LW +: LW] <= sy[LW-1:0];
			xcarry_q <= sx[LW +: CB+1];
			ycarry_q <= sy[LW +: CB+1];
		end
		if (cmd.emit) begin
			res_q.curve_x <= ex_x;
			res_q.curve_y <= ex_y;
		end
	end

	assign result = res_q;

endmodule

[hw/rtl/bezier_curve_point_eval.sv]
// Bezier curve point evaluator, Bernstein form, exact fixed point.
// Input item: start is taken when busy is low. mode 0 writes one control
// point (point_index, point_x, point_y) in that cycle and yields no result;
// busy stays low. mode 1 evaluates the curve at t_value (Q1.16, saturated
// to one) and raises busy until the evaluation ends.
// Result item: curve_x/curve_y are valid for exactly the one cycle in which
// done is high; the receiver cannot stall, so it must take the item then.
// point_count is written through cfg_we/cfg_wdata; the user must do so
// only while idle, as the block itself does not enforce it. An evaluate
// item works on n = point_count-1 and on NL/NAL limbs of the term and
// accumulator (NL = 8, NAL = 8 at eight points); the 16-bit limb
// multiplier builds each Bernstein term one t or (1-t) factor per limb
// pass, and the term is then added, scaled by its control point, into
// the accumulators.
// A new item may start in the cycle that done is high.
// Reset loads six default control points and a point count of six.
module bezier_curve_point_eval #(
	parameter int MAX_POINTS = bcpe_pkg::DEF_MAX_POINTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  bcpe_pkg::in_item_t            item,
	input  logic                          cfg_we,
	input  logic [bcpe_pkg::PCOUNT_W-1:0] cfg_wdata,
	output logic                          done,
	output bcpe_pkg::out_item_t           result
);

	bcpe_pkg::cmd_t cmd;

	bcpe_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.mode(item.mode),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.busy(busy),
		.done(done),
		.cmd(cmd)
	);

	bcpe_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.item(item),
		.result(result)
	);

endmodule
